@@ sv/zws_pkg.sv @@
`default_nettype none

package zws_pkg;

    localparam int ZONES_DEF   = 6;
    localparam int IDX_W       = 3;
    localparam int RUN_W       = 16;
    localparam int TIME_W      = 32;
    // start time plus at most 15 full run times stays below 2**33
    localparam int ACC_W       = 33;
    localparam int OP_W        = 2;
    localparam int IN_BITS     = IDX_W + RUN_W + TIME_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EARLY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_COPY,
        S_WALK
    } state_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } res_t;

endpackage

`default_nettype wire

@@ sv/zws_ram.sv @@
`default_nettype none

module zws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 6,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/zws_ctrl.sv @@
`default_nettype none

module zws_ctrl
    import zws_pkg::*;
#(
    parameter int ZONES = ZONES_DEF,
    parameter int ZW    = $clog2(ZONES + 1),
    parameter int AW    = (ZONES > 1) ? $clog2(ZONES) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire op_t               in_op,
    input  wire logic [IDX_W-1:0]  in_idx,
    input  wire logic [RUN_W-1:0]  in_run,
    input  wire logic [TIME_W-1:0] in_now,
    input  wire logic              out_free,
    output res_t                   res,
    output logic [ZW-1:0]          res_zone,
    output logic                   pend_we,
    output logic [AW-1:0]          pend_waddr,
    output logic [RUN_W-1:0]       pend_wdata,
    output logic [AW-1:0]          pend_raddr,
    input  wire logic [RUN_W-1:0]  pend_rdata,
    output logic                   act_we,
    output logic [AW-1:0]          act_waddr,
    output logic [RUN_W-1:0]       act_wdata,
    output logic [AW-1:0]          act_raddr,
    input  wire logic [RUN_W-1:0]  act_rdata
);

    localparam logic [ZW-1:0] IDLE_ZONE = ZW'(ZONES);
    localparam logic [AW-1:0] LAST_IDX  = AW'(ZONES - 1);

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [RUN_W-1:0]   rt_reg, rt_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [AW-1:0]      cnt_reg, cnt_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               found_reg, found_next;
    logic [ZW-1:0]      cur_reg, cur_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [ACC_W-1:0]   acc_sum;
    logic               idx_ok;

    assign acc_sum = acc_reg + ACC_W'(act_rdata);
    assign idx_ok  = {2'b00, idx_reg} < 5'(ZONES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cur_reg   <= IDLE_ZONE;
            start_reg <= '0;
            found_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            start_reg <= start_next;
            found_reg <= found_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        idx_reg <= idx_next;
        rt_reg  <= rt_next;
        now_reg <= now_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        rt_next    = rt_reg;
        now_next   = now_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        found_next = found_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        in_ready   = 1'b0;
        res.valid  = 1'b0;
        res.status = ST_OK;
        pend_we    = 1'b0;
        pend_waddr = AW'(idx_reg);
        pend_wdata = rt_reg;
        pend_raddr = '0;
        act_we     = 1'b0;
        act_waddr  = cnt_reg;
        act_wdata  = pend_rdata;
        act_raddr  = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero both tables, one entry per cycle
                pend_we    = 1'b1;
                pend_waddr = cnt_reg;
                pend_wdata = '0;
                act_we     = 1'b1;
                act_wdata  = '0;
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next    = in_op;
                    idx_next   = in_idx;
                    rt_next    = in_run;
                    now_next   = in_now;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the output slot can take this request's result
                if (out_free)
                begin
                    unique case (op_reg)
                        OP_LOAD:
                        begin
                            res.valid  = 1'b1;
                            state_next = S_IDLE;
                            if (idx_ok)
                            begin
                                pend_we = 1'b1;
                            end
                            else
                            begin
                                res.status = ST_RANGE;
                            end
                        end
                        OP_STOP:
                        begin
                            cur_next   = IDLE_ZONE;
                            start_next = '0;
                            res.valid  = 1'b1;
                            state_next = S_IDLE;
                        end
                        OP_START:
                        begin
                            cur_next   = IDLE_ZONE;
                            start_next = '0;
                            found_next = 1'b0;
                            cnt_next   = '0;
                            state_next = S_COPY;
                        end
                        OP_TICK:
                        begin
                            if (cur_reg == IDLE_ZONE)
                            begin
                                res.valid  = 1'b1;
                                state_next = S_IDLE;
                            end
                            else if (now_reg < start_reg)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_EARLY;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                acc_next   = ACC_W'(start_reg);
                                cnt_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_COPY:
            begin
                act_we     = 1'b1;
                pend_raddr = cnt_reg + AW'(1);
                if (!found_reg && (pend_rdata != '0))
                begin
                    found_next = 1'b1;
                    cur_next   = ZW'(cnt_reg);
                    start_next = now_reg;
                end
                if (cnt_reg == LAST_IDX)
                begin
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_WALK:
            begin
                act_raddr = cnt_reg + AW'(1);
                if ({1'b0, now_reg} < acc_sum)
                begin
                    cur_next   = ZW'(cnt_reg);
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    cur_next   = IDLE_ZONE;
                    start_next = '0;
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    acc_next = acc_sum;
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // table reads run one entry ahead of the index being processed
        if (state_reg == S_EXEC)
        begin
            pend_raddr = '0;
            act_raddr  = '0;
        end

        res_zone = cur_next;
    end

`ifndef SYNTH
    a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> out_free)
        else $error("result issued while output slot busy");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request not executed");

    a_zone_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_reg <= IDLE_ZONE)
        else $error("zone out of range");

    a_idle_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_reg == IDLE_ZONE) |-> (start_reg == '0))
        else $error("start time kept while idle");
`endif

endmodule

`default_nettype wire

@@ sv/zone_watering_sequencer.sv @@
`default_nettype none

// channel  dir  handshake             payload
// s_axis   in   tvalid/tready         tuser: opcode; tdata: zone_index, run_time, current_time
// m_axis   out  tvalid/tready         tdata: valve_mask, active, zone_now, status
//
// Load, stop and idle/early ticks pass through accept and execute; start then copies
// the pending table into the active one, and active ticks walk the active table until
// the zone is found or the table ends, with one table entry read per cycle.
// rst_n is asynchronous: run state idle, start time zero; a clearing pass then
// zeroes both tables, with s_axis_tready low until it ends.
// A result waits in the output register while the next request is taken; a new
// result stalls only when that register is still full.

module zone_watering_sequencer
    import zws_pkg::*;
#(
    parameter int ZONES = ZONES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // zone_index, run_time, current_time
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // opcode
    input  wire logic [OP_W-1:0]        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // valve_mask, active, zone_now, status
    output logic [((ZONES + $clog2(ZONES + 1) + 4 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int ZW       = $clog2(ZONES + 1);
    localparam int AW       = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam int VW       = ZONES + 1;
    localparam int OUT_BITS = VW + 1 + ZW + 2;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    res_t               res;
    logic [ZW-1:0]      res_zone;
    logic               out_free;
    logic               m_valid_reg;
    logic [ZW-1:0]      zone_reg;
    status_t            status_reg;
    logic               run_on;
    logic [VW-1:0]      valve_mask;

    logic               pend_we, act_we;
    logic [AW-1:0]      pend_waddr, pend_raddr, act_waddr, act_raddr;
    logic [RUN_W-1:0]   pend_wdata, pend_rdata, act_wdata, act_rdata;

    assign out_free = !m_valid_reg || m_axis_tready;

    zws_ram #(
        .WIDTH (RUN_W),
        .DEPTH (ZONES),
        .AW    (AW)
    ) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    zws_ram #(
        .WIDTH (RUN_W),
        .DEPTH (ZONES),
        .AW    (AW)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    zws_ctrl #(
        .ZONES (ZONES),
        .ZW    (ZW),
        .AW    (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (op_t'(s_axis_tuser)),
        .in_idx     (s_axis_tdata[IDX_W-1:0]),
        .in_run     (s_axis_tdata[IDX_W+RUN_W-1:IDX_W]),
        .in_now     (s_axis_tdata[IN_BITS-1:IDX_W+RUN_W]),
        .out_free   (out_free),
        .res        (res),
        .res_zone   (res_zone),
        .pend_we    (pend_we),
        .pend_waddr (pend_waddr),
        .pend_wdata (pend_wdata),
        .pend_raddr (pend_raddr),
        .pend_rdata (pend_rdata),
        .act_we     (act_we),
        .act_waddr  (act_waddr),
        .act_wdata  (act_wdata),
        .act_raddr  (act_raddr),
        .act_rdata  (act_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            zone_reg   <= res_zone;
            status_reg <= res.status;
        end
    end

    assign run_on     = zone_reg < ZW'(ZONES);
    assign valve_mask = run_on ? ((VW'(1) << zone_reg) | (VW'(1) << ZONES)) : '0;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, status_reg, zone_reg, run_on,
                            valve_mask};

endmodule

`default_nettype wire

@@ verif/zone_watering_sequencer_tb.sv @@
`timescale 1ns / 1ps

module zone_watering_sequencer_tb;
    import zws_pkg::*;

    localparam int ZONES       = ZONES_DEF;
    localparam int OUT_W       = ((ZONES + $clog2(ZONES + 1) + 4 + 7) / 8) * 8;
    localparam int PHASE_ITEMS = 430;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [ZONES:0] mask;
        logic           on;
        logic [2:0]     zone;
        status_t        st;
    } valves_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  idx;
        logic [15:0] rt;
        logic [31:0] now;
        logic        typed;
        valves_t     want;
    } dir_row_t;

    localparam valves_t IDLE_OK    = '{mask: '0, on: 1'b0, zone: 3'(ZONES), st: ST_OK};
    localparam valves_t IDLE_RANGE = '{mask: '0, on: 1'b0, zone: 3'(ZONES), st: ST_RANGE};
    localparam valves_t NO_CHECK   = '0;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;

    // predictor state
    logic [15:0] pend_run [ZONES];
    logic [15:0] act_run  [ZONES];
    int          open_zone;
    logic [31:0] run_start;

    valves_t valve_expect_q [$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      cycle_count    = 0;
    int      idle_pct       = 0;
    int      stall_pct      = 0;
    int      hold_len       = 0;

    dir_row_t dir_rows [25] = '{
        '{OP_TICK,  3'd0, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd7, 16'hFFFF,   32'd0,          1'b1, IDLE_RANGE},
        '{OP_LOAD,  3'd6, 16'd1,      32'd0,          1'b1, IDLE_RANGE},
        '{OP_LOAD,  3'd0, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd1, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd2, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd3, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd4, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd5, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_START, 3'd0, 16'd0,      32'd100,        1'b1, IDLE_OK},
        '{OP_LOAD,  3'd5, 16'hFFFF,   32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd2, 16'd10,     32'd0,          1'b1, IDLE_OK},
        '{OP_START, 3'd0, 16'd0,      32'hFFFF_FFF0,  1'b0, NO_CHECK},
        '{OP_TICK,  3'd0, 16'd0,      32'd0,          1'b0, NO_CHECK},
        '{OP_TICK,  3'd7, 16'hFFFF,   32'hFFFF_FFF9,  1'b0, NO_CHECK},
        '{OP_TICK,  3'd0, 16'd0,      32'hFFFF_FFFF,  1'b0, NO_CHECK},
        '{OP_STOP,  3'd0, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_STOP,  3'd0, 16'd0,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd0, 16'd1,      32'd0,          1'b1, IDLE_OK},
        '{OP_LOAD,  3'd1, 16'hFFFF,   32'd0,          1'b1, IDLE_OK},
        '{OP_START, 3'd0, 16'd0,      32'd0,          1'b0, NO_CHECK},
        '{OP_TICK,  3'd0, 16'd0,      32'd1,          1'b0, NO_CHECK},
        '{OP_START, 3'd0, 16'd0,      32'd5,          1'b0, NO_CHECK},
        '{OP_TICK,  3'd0, 16'd0,      32'hFFFF_FFFF,  1'b0, NO_CHECK},
        '{OP_TICK,  3'd0, 16'd0,      32'd0,          1'b1, IDLE_OK}
    };

    zone_watering_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int zone_for_time(logic [31:0] now);
        longint unsigned acc;
        acc = run_start;
        for (int z = 0; z < ZONES; z++)
        begin
            acc += act_run[z];
            if (now < acc)
                return z;
        end
        return ZONES;
    endfunction

    function automatic valves_t step_valves(op_t op, logic [2:0] idx, logic [15:0] rt,
                                            logic [31:0] now);
        valves_t r;
        int      nz;
        r.st = ST_OK;
        case (op)
            OP_TICK:
                if (open_zone < ZONES)
                begin
                    if (now < run_start)
                        r.st = ST_EARLY;
                    else
                    begin
                        nz = zone_for_time(now);
                        if (nz != open_zone)
                        begin
                            if (nz < ZONES)
                                open_zone = nz;
                            else
                            begin
                                open_zone = ZONES;
                                run_start = '0;
                            end
                        end
                    end
                end
            OP_LOAD:
                if (idx < ZONES)
                    pend_run[idx] = rt;
                else
                    r.st = ST_RANGE;
            OP_START:
            begin
                open_zone = ZONES;
                run_start = '0;
                act_run   = pend_run;
                for (int z = 0; z < ZONES; z++)
                begin
                    if (act_run[z] != 16'd0)
                    begin
                        open_zone = z;
                        run_start = now;
                        break;
                    end
                end
            end
            default:
            begin
                open_zone = ZONES;
                run_start = '0;
            end
        endcase
        r.mask = '0;
        if (open_zone < ZONES)
        begin
            r.mask[open_zone] = 1'b1;
            r.mask[ZONES]     = 1'b1;
        end
        r.on   = (open_zone < ZONES);
        r.zone = 3'(open_zone);
        return r;
    endfunction

    task automatic issue_request(op_t op, logic [2:0] idx, logic [15:0] rt, logic [31:0] now,
                                 logic typed, valves_t want);
        valves_t pred;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({now, rt, idx});
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = step_valves(op, idx, rt, now);
        valve_expect_q = {valve_expect_q, (typed ? want : pred)};
        items_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
        end
    endtask

    task automatic wait_drained;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (valve_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // loads, a start, then ticks walking forward through the run, with some early ticks, restarts or a stop
    task automatic water_session;
        int              n_load;
        int              n_tick;
        int              r;
        logic [15:0]     rt;
        logic [31:0]     t;
        logic [31:0]     back;
        longint unsigned total;
        longint unsigned step;
        longint unsigned nxt;
        n_load = $urandom_range(0, ZONES);
        for (int k = 0; k < n_load; k++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                issue_request(OP_LOAD, 3'($urandom_range(ZONES, 7)), 16'($urandom),
                              32'($urandom), 1'b0, NO_CHECK);
            else
            begin
                case ($urandom_range(0, 9))
                    0:       rt = 16'd0;
                    1:       rt = 16'($urandom);
                    default: rt = 16'($urandom_range(1, 12));
                endcase
                issue_request(OP_LOAD, 3'($urandom_range(0, ZONES - 1)), rt, 32'($urandom),
                              1'b0, NO_CHECK);
            end
        end
        case ($urandom_range(0, 7))
            0:       t = 32'hFFFF_FFFF - 32'($urandom_range(0, 60));
            1:       t = 32'($urandom_range(0, 30));
            default: t = 32'($urandom);
        endcase
        issue_request(OP_START, 3'($urandom), 16'($urandom), t, 1'b0, NO_CHECK);
        total = 0;
        for (int z = 0; z < ZONES; z++)
            total += act_run[z];
        step   = total / 5 + 2;
        t      = run_start;
        n_tick = $urandom_range(3, 24);
        for (int k = 0; k < n_tick; k++)
        begin
            r = $urandom_range(0, 29);
            if (r == 0)
            begin
                issue_request(OP_STOP, 3'($urandom), 16'($urandom), 32'($urandom),
                              1'b0, NO_CHECK);
                break;
            end
            else if (r <= 2)
            begin
                if (run_start != 0)
                begin
                    back = (run_start < 1000) ? run_start : 32'd1000;
                    issue_request(OP_TICK, 3'($urandom), 16'($urandom),
                                  run_start - 32'($urandom_range(1, back)), 1'b0, NO_CHECK);
                end
                else
                    issue_request(OP_TICK, 3'($urandom), 16'($urandom), 32'($urandom),
                                  1'b0, NO_CHECK);
            end
            else if (r == 3)
                issue_request(OP_START, 3'($urandom), 16'($urandom), t, 1'b0, NO_CHECK);
            else
            begin
                nxt = longint'(t) + $urandom_range(0, 32'(step));
                t   = (nxt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(nxt);
                issue_request(OP_TICK, 3'($urandom), 16'($urandom), t, 1'b0, NO_CHECK);
            end
            if (open_zone == ZONES && $urandom_range(0, 2) == 0)
                break;
        end
    endtask

    task automatic run_random(int n);
        int base;
        base = items_sent;
        while (items_sent - base < n)
        begin
            if ($urandom_range(0, 99) < 80)
                water_session();
            else
                issue_request(op_t'($urandom_range(0, 3)), 3'($urandom), 16'($urandom),
                              32'($urandom), 1'b0, NO_CHECK);
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_len--;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        valves_t got;
        valves_t want;
        got.mask = m_axis_tdata[ZONES:0];
        got.on   = m_axis_tdata[ZONES + 1];
        got.zone = m_axis_tdata[ZONES + 4:ZONES + 2];
        got.st   = status_t'(m_axis_tdata[ZONES + 6:ZONES + 5]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (valve_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: mask=%h on=%b zone=%0d status=%0d",
                             got.mask, got.on, got.zone, got.st);
            end
            else
            begin
                want = valve_expect_q.pop_front();
                if (got !== want || m_axis_tdata[OUT_W-1:ZONES + 7] !== '0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: exp mask=%h on=%b zone=%0d status=%0d",
                                  " | got mask=%h on=%b zone=%0d status=%0d tdata=%h"},
                                 want.mask, want.on, want.zone, want.st,
                                 got.mask, got.on, got.zone, got.st, m_axis_tdata);
                end
            end
        end
    end

    initial
    begin
        for (int z = 0; z < ZONES; z++)
        begin
            pend_run[z] = '0;
            act_run[z]  = '0;
        end
        open_zone = ZONES;
        run_start = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue_request(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].rt, dir_rows[i].now,
                          dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 73; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 73; end
                default: begin idle_pct = 31; stall_pct = 31; end
            endcase
            run_random(PHASE_ITEMS);
            wait_drained();
            if (p == 0)
            begin
                // long receiver hold-off so the block backs up into its input
                hold_len = 400;
                run_random(40);
                wait_drained();
            end
        end

        repeat (30) @(posedge clk);
        if (mismatch_count == 0 && valve_expect_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ zone_watering_sequencer.f @@
sv/zws_pkg.sv
sv/zws_ram.sv
sv/zws_ctrl.sv
sv/zone_watering_sequencer.sv
verif/zone_watering_sequencer_tb.sv
